@@ hdl/sem_pkg.sv @@
package sem_pkg;

   // One RGB pixel as stored in the line memory and the window: red, green, blue.
   localparam int PIX_W = 24;
   typedef logic [PIX_W-1:0] pixel_type;

   // Width of Gx^2 + Gy^2 for 8-bit channels: at most 2 * 1020^2.
   localparam int SUM_W = 21;
   typedef logic [SUM_W-1:0] sum_type;

   // Rounded root saturates at 255 once the sum reaches 255^2.
   localparam logic [SUM_W-1:0] ROOT_SAT = 21'd65025;
   localparam logic [7:0] ROOT_MAX = 8'd255;

   // One line memory word: the column's pixel from two rows up and from one row up.
   typedef struct packed {
      pixel_type upper;
      pixel_type middle;
   } line_word_type;

   // Configuration register indexes.
   localparam logic REG_WIDTH = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   localparam logic [11:0] WIDTH_RESET = 12'd640;
   localparam logic [12:0] HEIGHT_RESET = 13'd480;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_SQUARE,
      ST_ROOT,
      ST_LOAD
   } ctrl_state_type;

   typedef enum logic [1:0] {
      RT_IDLE,
      RT_STEP,
      RT_ROUND
   } root_state_type;

   // Handshake between the sequencer and one root unit.
   typedef struct packed {
      logic start;
      sum_type sum;
   } root_req_type;

   typedef struct packed {
      logic done;
      logic [7:0] mag;
   } root_rsp_type;

endpackage

@@ hdl/sem_line_store.sv @@
module sem_line_store #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                                 clock,
   input  logic                                 rd_en,
   input  logic [$clog2(MAX_WIDTH)-1:0]         rd_addr,
   output sem_pkg::line_word_type               rd_data_ff,
   input  logic                                 wr_en,
   input  logic [$clog2(MAX_WIDTH)-1:0]         wr_addr,
   input  sem_pkg::line_word_type               wr_data
);

   sem_pkg::line_word_type mem [MAX_WIDTH];

   // Single write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

@@ hdl/sem_grad.sv @@
module sem_grad (
   input  logic [8:0][7:0]    pix,
   output sem_pkg::sum_type   sum
);

   logic signed [10:0] p [9];
   logic signed [10:0] gx;
   logic signed [10:0] gy;
   logic signed [21:0] gx_sq;
   logic signed [21:0] gy_sq;

   // Zero-extend the channel values of the 3x3 block, row-major.
   always_comb begin
      for (int i = 0; i < 9; i++) begin
         p[i] = signed'({3'b000, pix[i]});
      end
   end

   // Sobel gradients and the sum of their squares.
   always_comb begin
      gx = p[2] - p[0] + 11'sd2 * (p[5] - p[3]) + p[8] - p[6];
      gy = p[6] - p[0] + 11'sd2 * (p[7] - p[1]) + p[8] - p[2];
      gx_sq = gx * gx;
      gy_sq = gy * gy;
      sum = sem_pkg::SUM_W'(gx_sq) + sem_pkg::SUM_W'(gy_sq);
   end

endmodule

@@ hdl/sem_root.sv @@
module sem_root (
   input  logic                    clock,
   input  logic                    reset,
   input  sem_pkg::root_req_type   req,
   output sem_pkg::root_rsp_type   rsp
);

   sem_pkg::root_state_type state_ff, state_in;
   sem_pkg::sum_type s_ff, s_in;
   logic [7:0] n_ff, n_in;
   logic [2:0] bit_ff, bit_in;
   logic [7:0] mag_ff, mag_in;
   logic done_ff, done_in;

   logic [7:0] trial;
   logic [15:0] trial_sq;
   logic [15:0] n_sq;
   sem_pkg::sum_type rem;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sem_pkg::RT_IDLE: begin
            if (req.start) state_in = sem_pkg::RT_STEP;
         end
         sem_pkg::RT_STEP: begin
            if (bit_ff == 3'd0) state_in = sem_pkg::RT_ROUND;
         end
         sem_pkg::RT_ROUND: begin
            state_in = sem_pkg::RT_IDLE;
         end
         default: state_in = sem_pkg::RT_IDLE;
      endcase
   end

   // One result bit per cycle, most significant first, then a rounding compare.
   always_comb begin
      trial = n_ff | (8'd1 << bit_ff);
      trial_sq = trial * trial;
      n_sq = n_ff * n_ff;
      rem = s_ff - sem_pkg::SUM_W'(n_sq);
      s_in = s_ff;
      n_in = n_ff;
      bit_in = bit_ff;
      mag_in = mag_ff;
      done_in = 1'b0;
      unique case (state_ff)
         sem_pkg::RT_IDLE: begin
            if (req.start) begin
               s_in = req.sum;
               n_in = 8'd0;
               bit_in = 3'd7;
            end
         end
         sem_pkg::RT_STEP: begin
            if (sem_pkg::SUM_W'(trial_sq) <= s_ff) n_in = trial;
            bit_in = bit_ff - 3'd1;
         end
         sem_pkg::RT_ROUND: begin
            done_in = 1'b1;
            if (s_ff >= sem_pkg::ROOT_SAT) begin
               mag_in = sem_pkg::ROOT_MAX;
            end else if (rem > sem_pkg::SUM_W'(n_ff)) begin
               mag_in = n_ff + 8'd1;
            end else begin
               mag_in = n_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sem_pkg::RT_IDLE;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      s_ff <= s_in;
      n_ff <= n_in;
      bit_ff <= bit_in;
      mag_ff <= mag_in;
   end

   assign rsp.done = done_ff;
   assign rsp.mag = mag_ff;

`ifndef SYNTHESIS
   // A start is only taken while the unit is free.
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      req.start |-> state_ff == sem_pkg::RT_IDLE)
      else $error("root start while busy");
   // The result is ready in the cycle after the rounding step.
   a_done_after_round: assert property (@(posedge clock) disable iff (reset)
      state_ff == sem_pkg::RT_ROUND |=> done_ff)
      else $error("root done missing");
   // The root never exceeds 255 and stays consistent with the saturation rule.
   a_sat: assert property (@(posedge clock) disable iff (reset)
      state_ff == sem_pkg::RT_ROUND && s_ff >= sem_pkg::ROOT_SAT |=> mag_ff == sem_pkg::ROOT_MAX)
      else $error("root saturation wrong");
`endif

endmodule

@@ hdl/sobel_edge_magnitude_rgb.sv @@
// A pixel whose result is released passes from acceptance through the line memory read,
// fetch, gradient, bit-serial 8-step square root, rounding and output load to rsp_valid;
// an item that releases no result ends with the line memory read and write-back, and an
// ignored drain tick is only accepted. Items are taken one at a time: req_stall stays
// high until the sequencer is idle, and the output load waits while rsp_stall holds.
// Reset (synchronous, active high) clears the sequencer, raster counters and window and
// loads width 640 and height 480; line memory contents stay undefined until written.
module sobel_edge_magnitude_rgb #(
   parameter int MAX_WIDTH = 2048,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [7:0]  req_pixel_red,
   input  logic [7:0]  req_pixel_green,
   input  logic [7:0]  req_pixel_blue,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_edge_red,
   output logic [7:0]  rsp_edge_green,
   output logic [7:0]  rsp_edge_blue,
   output logic        rsp_frame_end,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int RW = $clog2(MAX_HEIGHT + 2);

   sem_pkg::ctrl_state_type state_ff, state_in;

   logic [11:0] cfg_width_ff, cfg_width_in;
   logic [12:0] cfg_height_ff, cfg_height_in;
   logic cfg_write;

   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [WW-1:0] w_eff;
   logic [HW-1:0] h_eff;

   logic accept;
   logic is_drain;
   logic ignore;
   logic row_past;
   logic col_wrap;

   // Attributes of the transaction in flight.
   logic [CW-1:0] c_ff, c_in;
   sem_pkg::pixel_type pix_ff, pix_in;
   logic upd_ff, upd_in;
   logic use_up_ff, use_up_in;
   logic use_mid_ff, use_mid_in;
   logic emit_ff, emit_in;
   logic restart_ff, restart_in;

   logic [2:0][2:0][sem_pkg::PIX_W-1:0] win_ff, win_in;
   logic [8:0][sem_pkg::PIX_W-1:0] blk_ff, blk_in;
   sem_pkg::pixel_type col_px [3];

   sem_pkg::line_word_type rd_data;
   sem_pkg::line_word_type wr_data;
   logic mem_we;

   logic root_start;
   sem_pkg::root_req_type root_req [3];
   sem_pkg::root_rsp_type root_rsp [3];
   logic roots_done;

   logic out_free;
   logic out_load;
   logic out_valid_ff, out_valid_in;
   logic [7:0] out_red_ff, out_green_ff, out_blue_ff;
   logic out_end_ff;

   // Configuration port.
   assign csr_pready = 1'b1;
   assign cfg_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_width_in = cfg_width_ff;
      cfg_height_in = cfg_height_ff;
      if (cfg_write) begin
         unique case (csr_paddr[2])
            sem_pkg::REG_WIDTH: cfg_width_in = csr_pwdata[11:0];
            sem_pkg::REG_HEIGHT: cfg_height_in = csr_pwdata[12:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         sem_pkg::REG_WIDTH: csr_prdata = 32'(cfg_width_ff);
         sem_pkg::REG_HEIGHT: csr_prdata = 32'(cfg_height_ff);
         default: csr_prdata = '0;
      endcase
   end

   // Effective frame size, clamped to the supported range.
   always_comb begin
      if (cfg_width_ff == '0) begin
         w_eff = WW'(1);
      end else if (32'(cfg_width_ff) > 32'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(cfg_width_ff);
      end
      if (cfg_height_ff == '0) begin
         h_eff = HW'(1);
      end else if (32'(cfg_height_ff) > 32'(MAX_HEIGHT)) begin
         h_eff = HW'(MAX_HEIGHT);
      end else begin
         h_eff = HW'(cfg_height_ff);
      end
   end

   // Raster position decode. Row h+1 column 0 is the final drain tick of a frame.
   assign accept = req_valid && !req_stall;
   assign is_drain = req_type;
   assign ignore = is_drain && ((RW + 1)'(row_ff) < (RW + 1)'(h_eff));
   assign row_past = (RW + 1)'(row_ff) >= (RW + 1)'(h_eff) + (RW + 1)'(1);
   assign col_wrap = (CW + 1)'(col_ff) + (CW + 1)'(1) >= (CW + 1)'(w_eff);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      c_in = c_ff;
      pix_in = pix_ff;
      upd_in = upd_ff;
      use_up_in = use_up_ff;
      use_mid_in = use_mid_ff;
      emit_in = emit_ff;
      restart_in = restart_ff;
      if (cfg_write) begin
         col_in = '0;
         row_in = '0;
      end else if (accept && !ignore) begin
         c_in = col_ff;
         upd_in = (RW + 1)'(row_ff) < (RW + 1)'(h_eff);
         pix_in = (!is_drain && upd_in) ?
            {req_pixel_red, req_pixel_green, req_pixel_blue} : '0;
         use_up_in = row_ff >= RW'(2);
         use_mid_in = row_ff >= RW'(1);
         emit_in = (row_ff >= RW'(2)) || (row_ff == RW'(1) && col_ff != '0);
         restart_in = row_past;
         if (row_past) begin
            col_in = '0;
            row_in = '0;
         end else if (col_wrap) begin
            col_in = '0;
            row_in = row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sem_pkg::ST_IDLE: begin
            if (accept && !ignore) state_in = sem_pkg::ST_FETCH;
         end
         sem_pkg::ST_FETCH: begin
            state_in = emit_ff ? sem_pkg::ST_SQUARE : sem_pkg::ST_IDLE;
         end
         sem_pkg::ST_SQUARE: begin
            state_in = sem_pkg::ST_ROOT;
         end
         sem_pkg::ST_ROOT: begin
            if (roots_done) state_in = sem_pkg::ST_LOAD;
         end
         sem_pkg::ST_LOAD: begin
            if (out_free) state_in = sem_pkg::ST_IDLE;
         end
         default: state_in = sem_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   assign out_free = !out_valid_ff || !rsp_stall;
   always_comb begin
      req_stall = 1'b1;
      mem_we = 1'b0;
      root_start = 1'b0;
      out_load = 1'b0;
      unique case (state_ff)
         sem_pkg::ST_IDLE: req_stall = 1'b0;
         sem_pkg::ST_FETCH: mem_we = upd_ff;
         sem_pkg::ST_SQUARE: root_start = 1'b1;
         sem_pkg::ST_ROOT: ;
         sem_pkg::ST_LOAD: out_load = out_free;
         default: ;
      endcase
   end

   // Line memory: read at acceptance, written back in the fetch cycle.
   assign wr_data.upper = rd_data.middle;
   assign wr_data.middle = pix_ff;

   sem_line_store #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_line_store (
      .clock(clock),
      .rd_en(accept),
      .rd_addr(col_ff),
      .rd_data_ff(rd_data),
      .wr_en(mem_we),
      .wr_addr(c_ff),
      .wr_data(wr_data)
   );

   // Window shift and capture of the 3x3 block for the result.
   always_comb begin
      col_px[0] = use_up_ff ? rd_data.upper : '0;
      col_px[1] = use_mid_ff ? rd_data.middle : '0;
      col_px[2] = pix_ff;
      win_in = win_ff;
      blk_in = blk_ff;
      if (cfg_write) begin
         win_in = '0;
      end else if (state_ff == sem_pkg::ST_FETCH) begin
         for (int r = 0; r < 3; r++) begin
            blk_in[r * 3] = win_ff[r][1];
            blk_in[r * 3 + 1] = win_ff[r][2];
            blk_in[r * 3 + 2] = (c_ff == '0) ? '0 : col_px[r];
            win_in[r][0] = (c_ff == '0) ? '0 : win_ff[r][1];
            win_in[r][1] = (c_ff == '0) ? '0 : win_ff[r][2];
            win_in[r][2] = col_px[r];
         end
         if (restart_ff) win_in = '0;
      end
   end

   // One gradient and root unit per color channel.
   for (genvar ch = 0; ch < 3; ch++) begin : g_chan
      logic [8:0][7:0] chan_pix;
      sem_pkg::sum_type chan_sum;

      always_comb begin
         for (int i = 0; i < 9; i++) begin
            chan_pix[i] = blk_ff[i][(2 - ch) * 8 +: 8];
         end
      end

      sem_grad u_grad (
         .pix(chan_pix),
         .sum(chan_sum)
      );

      assign root_req[ch].start = root_start;
      assign root_req[ch].sum = chan_sum;

      sem_root u_root (
         .clock(clock),
         .reset(reset),
         .req(root_req[ch]),
         .rsp(root_rsp[ch])
      );
   end

   assign roots_done = root_rsp[0].done && root_rsp[1].done && root_rsp[2].done;

   // Output register.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_red_ff <= root_rsp[0].mag;
         out_green_ff <= root_rsp[1].mag;
         out_blue_ff <= root_rsp[2].mag;
         out_end_ff <= restart_ff;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_edge_red = out_red_ff;
   assign rsp_edge_green = out_green_ff;
   assign rsp_edge_blue = out_blue_ff;
   assign rsp_frame_end = out_end_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sem_pkg::ST_IDLE;
         cfg_width_ff <= sem_pkg::WIDTH_RESET;
         cfg_height_ff <= sem_pkg::HEIGHT_RESET;
         col_ff <= '0;
         row_ff <= '0;
         win_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cfg_width_ff <= cfg_width_in;
         cfg_height_ff <= cfg_height_in;
         col_ff <= col_in;
         row_ff <= row_in;
         win_ff <= win_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Transaction attributes and captured block.
   always_ff @(posedge clock) begin
      c_ff <= c_in;
      pix_ff <= pix_in;
      upd_ff <= upd_in;
      use_up_ff <= use_up_in;
      use_mid_ff <= use_mid_in;
      emit_ff <= emit_in;
      restart_ff <= restart_in;
      blk_ff <= blk_in;
   end

`ifndef SYNTHESIS
   // A transaction that is not an ignored drain tick always goes to the fetch cycle.
   a_accept_fetch: assert property (@(posedge clock) disable iff (reset)
      accept && !ignore && !cfg_write |=> state_ff == sem_pkg::ST_FETCH)
      else $error("accepted transaction did not reach fetch");
   // The root units finish only while the sequencer waits for them.
   a_root_done_state: assert property (@(posedge clock) disable iff (reset)
      roots_done |-> state_ff == sem_pkg::ST_ROOT)
      else $error("root result outside root wait");
   // The column counter stays inside the current frame width.
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      (CW + 1)'(col_ff) < (CW + 1)'(w_eff))
      else $error("column beyond frame width");
   // A stalled result is never overwritten by the next one.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_stall |-> !out_load)
      else $error("output register overwritten");
`endif

endmodule

@@ dv/edge_magnitude_checker.sv @@
`timescale 1ns / 100ps

// Watches the pixel, edge and register channels of the Sobel block, predicts every
// edge transaction from the accepted pixel transactions and compares field by field.
module edge_magnitude_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_type,
   input  logic [7:0]  req_pixel_red,
   input  logic [7:0]  req_pixel_green,
   input  logic [7:0]  req_pixel_blue,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [7:0]  rsp_edge_red,
   input  logic [7:0]  rsp_edge_green,
   input  logic [7:0]  rsp_edge_blue,
   input  logic        rsp_frame_end,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          fail_count,
   output int          pending_count
);

   localparam int LINE_DEPTH = 2048;
   localparam int ROW_LIMIT = 4096;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       frame_end;
   } edge_result_type;

   edge_result_type expected_edges[$];

   logic [11:0] width_reg;
   logic [12:0] height_reg;
   sem_pkg::pixel_type upper_mem [LINE_DEPTH];
   sem_pkg::pixel_type middle_mem [LINE_DEPTH];
   sem_pkg::pixel_type win [3][3];
   sem_pkg::pixel_type blk [3][3];
   int unsigned col_pos;
   int unsigned row_pos;
   int unsigned out_pos;

   assign pending_count = expected_edges.size();

   // Integer square root, rounded half up and saturated at 255.
   function automatic logic [7:0] rounded_root(input int unsigned s);
      int unsigned n;
      int unsigned t;
      if (s >= 65025) return sem_pkg::ROOT_MAX;
      n = 0;
      for (int b = 128; b != 0; b = b >> 1) begin
         t = n | b;
         if (t * t <= s) n = t;
      end
      if (s - n * n > n) n++;
      return (n > 255) ? sem_pkg::ROOT_MAX : n[7:0];
   endfunction

   // Sobel magnitude of one color channel of the current block.
   function automatic logic [7:0] channel_edge(input int sh);
      int p [3][3];
      int gx;
      int gy;
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            p[r][c] = int'((blk[r][c] >> sh) & 24'hFF);
      gx = -p[0][0] + p[0][2] - 2 * p[1][0] + 2 * p[1][2] - p[2][0] + p[2][2];
      gy = -p[0][0] - 2 * p[0][1] - p[0][2] + p[2][0] + 2 * p[2][1] + p[2][2];
      return rounded_root(gx * gx + gy * gy);
   endfunction

   task automatic restart_frame();
      col_pos = 0;
      row_pos = 0;
      out_pos = 0;
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            win[r][c] = '0;
   endtask

   // Advances the raster by one accepted transaction and queues any released edge.
   task automatic advance_raster(input logic is_drain, input sem_pkg::pixel_type px_in);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned a;
      int unsigned total;
      sem_pkg::pixel_type pix;
      sem_pkg::pixel_type col [3];
      edge_result_type res;
      w = width_reg;
      h = height_reg;
      if (w < 1) w = 1;
      if (w > LINE_DEPTH) w = LINE_DEPTH;
      if (h < 1) h = 1;
      if (h > ROW_LIMIT) h = ROW_LIMIT;
      c = (col_pos >= w) ? 0 : col_pos;
      total = h * w;
      a = row_pos * w + c;

      // A drain tick before the frame is complete is dropped.
      if (is_drain && row_pos < h) return;

      pix = (!is_drain && row_pos < h) ? px_in : '0;
      col[0] = (row_pos >= 2) ? upper_mem[c] : '0;
      col[1] = (row_pos >= 1) ? middle_mem[c] : '0;
      col[2] = pix;

      if (a >= w + 1) begin
         for (int r = 0; r < 3; r++) begin
            blk[r][0] = win[r][1];
            blk[r][1] = win[r][2];
            blk[r][2] = (c == 0) ? '0 : col[r];
         end
         res.red = channel_edge(16);
         res.green = channel_edge(8);
         res.blue = channel_edge(0);
         res.frame_end = (out_pos == total - 1);
         expected_edges.push_back(res);
         out_pos++;
      end

      for (int r = 0; r < 3; r++) begin
         win[r][0] = (c == 0) ? '0 : win[r][1];
         win[r][1] = (c == 0) ? '0 : win[r][2];
         win[r][2] = col[r];
      end

      if (row_pos < h) begin
         upper_mem[c] = middle_mem[c];
         middle_mem[c] = pix;
      end

      if (a >= total + w) begin
         restart_frame();
      end else begin
         c++;
         if (c >= w) begin
            c = 0;
            row_pos++;
         end
         col_pos = c;
      end
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t: edge mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   initial fail_count = 0;

   // Sample every channel at the clock edge and keep the prediction in step.
   always @(posedge clock) begin
      edge_result_type want;
      if (reset) begin
         width_reg = sem_pkg::WIDTH_RESET;
         height_reg = sem_pkg::HEIGHT_RESET;
         expected_edges.delete();
         for (int i = 0; i < LINE_DEPTH; i++) begin
            upper_mem[i] = '0;
            middle_mem[i] = '0;
         end
         restart_frame();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
               && csr_paddr[1:0] == 2'b00) begin
            if (csr_paddr[2] == sem_pkg::REG_WIDTH) begin
               width_reg = csr_pwdata[11:0];
            end else begin
               height_reg = csr_pwdata[12:0];
            end
            restart_frame();
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_edges.size() == 0) begin
               // An edge transaction arrived with none outstanding.
               report_mismatch("transaction count", 1, 0);
            end else begin
               want = expected_edges.pop_front();
               if (rsp_edge_red !== want.red)
                  report_mismatch("red", rsp_edge_red, want.red);
               if (rsp_edge_green !== want.green)
                  report_mismatch("green", rsp_edge_green, want.green);
               if (rsp_edge_blue !== want.blue)
                  report_mismatch("blue", rsp_edge_blue, want.blue);
               if (rsp_frame_end !== want.frame_end)
                  report_mismatch("frame_end", rsp_frame_end, want.frame_end);
            end
         end
         if (req_valid && !req_stall)
            advance_raster(req_type,
                           {req_pixel_red, req_pixel_green, req_pixel_blue});
      end
   end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

   localparam int CYCLE_LIMIT = 600000;
   localparam int SETTLE_CYCLES = 20;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_type = 1'b0;
   logic [7:0]  req_pixel_red = '0;
   logic [7:0]  req_pixel_green = '0;
   logic [7:0]  req_pixel_blue = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_edge_red;
   logic [7:0]  rsp_edge_green;
   logic [7:0]  rsp_edge_blue;
   logic        rsp_frame_end;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int fail_count;
   int pending_count;
   int send_gap_pct = 0;
   int recv_gap_pct = 0;
   bit hold_output = 1'b0;
   int pixels_sent = 0;
   int cycle_count = 0;

   always #5 clock = ~clock;

   sobel_edge_magnitude_rgb u_dut (.*);

   edge_magnitude_checker u_checker (.*);

   // Receiver side: random stalls, or a solid hold-off while one is requested.
   always @(posedge clock) begin
      rsp_stall <= hold_output || ($urandom_range(99) < recv_gap_pct);
   end

   // Run watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   function automatic logic [7:0] pick_channel();
      case ($urandom_range(9))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // Offers one transaction on the pixel channel and waits for acceptance.
   task automatic send_item(input logic is_drain, input logic [7:0] r, g, b);
      if ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= is_drain;
      req_pixel_red <= r;
      req_pixel_green <= g;
      req_pixel_blue <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pixels_sent++;
   endtask

   task automatic send_pixel();
      send_item(1'b0, pick_channel(), pick_channel(), pick_channel());
   endtask

   // Stops offering and waits until every expected edge has come back.
   task automatic quiesce();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic index, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic set_frame(input int w, input int h);
      csr_write(sem_pkg::REG_WIDTH, {20'($urandom_range(1048575)), 12'(w)});
      csr_write(sem_pkg::REG_HEIGHT, {19'($urandom_range(524287)), 13'(h)});
   endtask

   // One frame: pixels with stray drain ticks, then the drain tail where some
   // ticks are pixels. A partial frame stops early and is abandoned later.
   task automatic run_frame(input int w, input int h, input bit partial);
      int ew;
      int eh;
      int stop;
      ew = (w < 1) ? 1 : ((w > 2048) ? 2048 : w);
      eh = (h < 1) ? 1 : ((h > 4096) ? 4096 : h);
      stop = partial ? $urandom_range(1, ew * eh) : ew * eh;
      for (int i = 0; i < stop; i++) begin
         if ($urandom_range(99) < 5)
            send_item(1'b1, pick_channel(), pick_channel(), pick_channel());
         send_pixel();
      end
      if (!partial) begin
         for (int i = 0; i <= ew; i++)
            send_item($urandom_range(99) < 15 ? 1'b0 : 1'b1,
                      pick_channel(), pick_channel(), pick_channel());
      end
   endtask

   initial begin
      int w;
      int h;
      int target;
      bit was_partial;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: a few pixels at the reset size, then abandon the frame.
      repeat (3) send_pixel();
      quiesce();

      // Directed: 3x3 with saturating contrast, a stray drain and a pixel in the tail.
      set_frame(3, 3);
      send_item(1'b0, 8'd255, 8'd0, 8'd255);
      send_item(1'b1, 8'd0, 8'd0, 8'd0);
      send_item(1'b0, 8'd0, 8'd255, 8'd0);
      send_item(1'b0, 8'd255, 8'd0, 8'd255);
      for (int i = 0; i < 6; i++)
         send_item(1'b0, 8'(i[0] ? 0 : 255), 8'(i[0] ? 255 : 0), 8'd128);
      send_item(1'b0, 8'd1, 8'd2, 8'd3);
      repeat (3) send_item(1'b1, 8'd0, 8'd0, 8'd0);
      // Same size again without a write: the frame wraps.
      run_frame(3, 3, 1'b0);
      quiesce();

      // Zero width and height act as one.
      set_frame(0, 0);
      run_frame(1, 1, 1'b0);
      quiesce();

      // Oversized registers clamp; a few pixels, then the frame is abandoned.
      set_frame(4095, 2);
      repeat (4) send_pixel();
      quiesce();
      set_frame(1, 8191);
      repeat (5) send_pixel();
      quiesce();

      // Random frames under three idling profiles.
      for (int phase = 0; phase < 3; phase++) begin
         send_gap_pct = (phase == 0) ? 24 : ((phase == 1) ? 59 : 0);
         recv_gap_pct = (phase == 0) ? 59 : ((phase == 1) ? 24 : 0);
         target = pixels_sent + 200;
         was_partial = 1'b1;
         w = 1;
         h = 1;
         while (pixels_sent < target) begin
            if (was_partial || $urandom_range(99) < 75) begin
               quiesce();
               case ($urandom_range(9))
                  0, 1: w = $urandom_range(7, 20);
                  default: w = $urandom_range(1, 6);
               endcase
               h = $urandom_range(1, 5);
               set_frame(w, h);
            end
            if (phase == 2 && !hold_output && $urandom_range(3) == 0) begin
               // Long receiver hold-off while pixels keep coming.
               fork
                  begin
                     hold_output = 1'b1;
                     repeat (400) @(posedge clock);
                     hold_output = 1'b0;
                  end
               join_none
            end
            was_partial = ($urandom_range(99) < 10);
            run_frame(w, h, was_partial);
         end
         quiesce();
      end

      wait (!hold_output);
      quiesce();
      if (fail_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
